/* rtl/core/qspc_pkg.sv */
// qspc_pkg: shared types, constants and the quadrature step table for the
// quadrature speed PI controller. No dependencies.
package qspc_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int KP_W       = 8;
  localparam int KI_W       = 16;
  localparam int LIMIT_W    = 20;
  localparam int CFG_W      = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int INTEG_W    = 21;
  localparam int SETPOINT_W = 16;
  localparam int WORD_W     = 32;
  localparam int ITERM_W    = 27;
  localparam int FAULT_W    = 16;
  localparam int DUTY_W     = 8;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 184;

  // I term divide by 1000: the 37-bit magnitude is shifted right by 3, then
  // divided by 125 with a reciprocal multiply, exact for magnitudes below 2^37
  localparam int     DIV_W       = 37;
  localparam int     DIV_SHIFT   = 3;
  localparam int     RECIP_IN_W  = DIV_W - DIV_SHIFT;
  localparam int     HALF_W      = RECIP_IN_W / 2;
  localparam int     RECIP_W     = 35;
  localparam longint RECIP       = 64'sd17592186045;  // ceil(2^41 / 125)
  localparam int     RECIP_SHIFT = 41;
  localparam int     QUOT_W      = RECIP_IN_W + RECIP_W - RECIP_SHIFT;

  localparam logic OP_PIN  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP    = 2'd0,
    REG_KI    = 2'd1,
    REG_LIMIT = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    STEP_HOLD,
    STEP_UP,
    STEP_DOWN,
    STEP_BAD
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INTEG,
    ST_MUL,
    ST_ABS,
    ST_DIV,
    ST_SUM,
    ST_ITERM,
    ST_OUT
  } back_state_t;

  typedef struct packed {
    logic [KP_W-1:0]    kp;
    logic [KI_W-1:0]    ki_times_period;
    logic [LIMIT_W-1:0] integrator_limit;
  } cfg_t;

  // One tick as classified by the front end
  typedef struct packed {
    logic [WORD_W-1:0]  speed_error;
    logic [WORD_W-1:0]  speed;
    logic [WORD_W-1:0]  position;
    logic [FAULT_W-1:0] fault_count;
  } tick_rec_t;

  // Result word, duty in the lowest bits
  typedef struct packed {
    logic [FAULT_W-1:0] fault_count;
    logic [WORD_W-1:0]  speed;
    logic [WORD_W-1:0]  position;
    logic [ITERM_W-1:0] i_term;
    logic [WORD_W-1:0]  p_term;
    logic [WORD_W-1:0]  speed_error;
    logic [DUTY_W-1:0]  duty;
  } result_t;

  // index = {last B, last A, cur B, cur A}
  function automatic step_t step_lookup(input logic [3:0] idx);
    step_t s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:  s = STEP_DOWN;
      4'd2, 4'd4, 4'd11, 4'd13: s = STEP_UP;
      4'd3, 4'd6, 4'd9, 4'd12:  s = STEP_BAD;
      default:                  s = STEP_HOLD;
    endcase
    return s;
  endfunction

endpackage

/* rtl/core/qspc_front.sv */
// qspc_front: accepts input words, decodes encoder pins, classifies ticks.
// Depends on qspc_pkg.
module qspc_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [qspc_pkg::IN_DATA_W-1:0]      s_tdata,  // pin_a, pin_b, setpoint[15:0], pad
  input  logic                                s_tuser,  // opcode
  input  logic                                full,
  output logic                                push,
  output qspc_pkg::tick_rec_t                 push_rec
);
  import qspc_pkg::*;

  logic [1:0]         last_pins;
  logic [WORD_W-1:0]  edge_position;
  logic [WORD_W-1:0]  position_at_last_tick;
  logic [FAULT_W-1:0] invalid_count;

  logic               accept;
  logic [1:0]         cur_pins;
  step_t              step;
  logic [WORD_W-1:0]  speed;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;
  assign cur_pins = s_tdata[1:0];
  assign step     = step_lookup({last_pins, cur_pins});
  assign speed    = edge_position - position_at_last_tick;
  assign push     = accept && (s_tuser == OP_TICK);

  always_comb begin
    push_rec.speed       = speed;
    push_rec.speed_error = {{(WORD_W-SETPOINT_W){1'b0}}, s_tdata[SETPOINT_W+1:2]} - speed;
    push_rec.position    = edge_position;
    push_rec.fault_count = invalid_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pins             <= '0;
      edge_position         <= '0;
      position_at_last_tick <= '0;
      invalid_count         <= '0;
    end else if (accept) begin
      if (s_tuser == OP_PIN) begin
        last_pins <= cur_pins;
        case (step)
          STEP_UP:   edge_position <= edge_position + WORD_W'(1);
          STEP_DOWN: edge_position <= edge_position - WORD_W'(1);
          STEP_BAD:  invalid_count <= invalid_count + FAULT_W'(1);
          default:   ;
        endcase
      end else begin
        position_at_last_tick <= edge_position;
      end
    end
  end

endmodule

/* rtl/core/qspc_fifo.sv */
// qspc_fifo: short queue of tick records between front and back end.
// Depends on qspc_pkg.
module qspc_fifo #(
  parameter int DEPTH = qspc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  qspc_pkg::tick_rec_t push_data,
  output logic                full,
  input  logic                pop,
  output qspc_pkg::tick_rec_t pop_data,
  output logic                empty
);
  import qspc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tick_rec_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)
        count <= count + CNT_W'(1);
      else if (pop && !push)
        count <= count - CNT_W'(1);
    end
  end

endmodule

/* rtl/core/qspc_back.sv */
// qspc_back: PI step sequencer (integrator, P/I multiplies, divide by 1000,
// duty clamp) and the output register. Depends on qspc_pkg.
module qspc_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  qspc_pkg::cfg_t                       cfg,
  input  logic                                 empty,
  input  qspc_pkg::tick_rec_t                  pop_data,
  output logic                                 pop,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [qspc_pkg::OUT_DATA_W-1:0]      m_tdata
);
  import qspc_pkg::*;

  localparam int PPROD_W = WORD_W + KP_W + 1;
  localparam int IPROD_W = INTEG_W + KI_W + 1;
  localparam int SUM_W   = WORD_W + 1;
  localparam int PP_W    = HALF_W + RECIP_W;
  localparam int RPROD_W = RECIP_IN_W + RECIP_W;
  localparam int QS_W    = QUOT_W + 1;

  localparam logic signed [PPROD_W-1:0] P_MAX = PPROD_W'(64'sd2147483647);
  localparam logic signed [PPROD_W-1:0] P_MIN = PPROD_W'(-64'sd2147483648);
  localparam logic signed [QS_W-1:0]    I_MAX = QS_W'(64'sd67108863);
  localparam logic signed [QS_W-1:0]    I_MIN = QS_W'(-64'sd67108864);
  localparam logic [PP_W-1:0]           RECIP_C = PP_W'(RECIP);

  back_state_t state, state_next;

  tick_rec_t                  rec;
  logic signed [INTEG_W-1:0]  integral;
  logic signed [PPROD_W-1:0]  p_prod;
  logic signed [WORD_W-1:0]   p_sat;
  logic signed [IPROD_W-1:0]  i_prod;
  logic                       i_neg;
  logic [RECIP_IN_W-1:0]      i_mag;
  logic [PP_W-1:0]            pp_lo;
  logic [PP_W-1:0]            pp_hi;
  logic [QUOT_W-1:0]          quot;
  logic signed [ITERM_W-1:0]  i_term;
  logic                       out_load;

  logic signed [SUM_W-1:0]    integ_sum;
  logic signed [SUM_W-1:0]    lim_pos;
  logic signed [SUM_W-1:0]    lim_neg;
  logic signed [IPROD_W-1:0]  i_abs;
  logic [RPROD_W-1:0]         r_prod;
  logic signed [QS_W-1:0]     q_signed;
  logic signed [SUM_W-1:0]    duty_sum;
  logic [DUTY_W-1:0]          duty;
  result_t                    result;

  always_comb begin
    integ_sum = {{(SUM_W-INTEG_W){integral[INTEG_W-1]}}, integral}
              + {rec.speed_error[WORD_W-1], rec.speed_error};
    lim_pos   = {{(SUM_W-LIMIT_W){1'b0}}, cfg.integrator_limit};
    lim_neg   = -lim_pos;
    i_abs     = i_prod[IPROD_W-1] ? -i_prod : i_prod;
    // magnitude / 8 times the reciprocal of 125, from the two partial products
    r_prod    = {pp_hi, {HALF_W{1'b0}}} + {{(RPROD_W-PP_W){1'b0}}, pp_lo};
    q_signed  = i_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    duty_sum  = {p_sat[WORD_W-1], p_sat} + {{(SUM_W-ITERM_W){i_term[ITERM_W-1]}}, i_term};
    if (duty_sum < 0)
      duty = '0;
    else if (duty_sum > SUM_W'(255))
      duty = '1;
    else
      duty = duty_sum[DUTY_W-1:0];
  end

  always_comb begin
    result.duty        = duty;
    result.speed_error = rec.speed_error;
    result.p_term      = p_sat;
    result.i_term      = i_term;
    result.position    = rec.position;
    result.speed       = rec.speed;
    result.fault_count = rec.fault_count;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (!empty) state_next = ST_INTEG;
      ST_INTEG: state_next = ST_MUL;
      ST_MUL:   state_next = ST_ABS;
      ST_ABS:   state_next = ST_DIV;
      ST_DIV:   state_next = ST_SUM;
      ST_SUM:   state_next = ST_ITERM;
      ST_ITERM: state_next = ST_OUT;
      ST_OUT:   if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE: pop      = !empty;
      ST_OUT:  out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      integral <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_INTEG) begin
        if (integ_sum > lim_pos)
          integral <= lim_pos[INTEG_W-1:0];
        else if (integ_sum < lim_neg)
          integral <= lim_neg[INTEG_W-1:0];
        else
          integral <= integ_sum[INTEG_W-1:0];
      end
      if (out_load)
        m_tvalid <= 1'b1;
      else if (m_tready)
        m_tvalid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (pop) rec <= pop_data;
    case (state)
      ST_INTEG: p_prod <= $signed(rec.speed_error) * $signed({1'b0, cfg.kp});
      ST_MUL: begin
        i_prod <= integral * $signed({1'b0, cfg.ki_times_period});
        if (p_prod > P_MAX)
          p_sat <= P_MAX[WORD_W-1:0];
        else if (p_prod < P_MIN)
          p_sat <= P_MIN[WORD_W-1:0];
        else
          p_sat <= p_prod[WORD_W-1:0];
      end
      ST_ABS: begin
        i_neg <= i_prod[IPROD_W-1];
        i_mag <= i_abs[DIV_W-1:DIV_SHIFT];
      end
      ST_DIV: begin
        pp_lo <= PP_W'(i_mag[HALF_W-1:0]) * RECIP_C;
        pp_hi <= PP_W'(i_mag[RECIP_IN_W-1:HALF_W]) * RECIP_C;
      end
      ST_SUM: quot <= r_prod[RPROD_W-1:RECIP_SHIFT];
      ST_ITERM: begin
        if (q_signed > I_MAX)
          i_term <= I_MAX[ITERM_W-1:0];
        else if (q_signed < I_MIN)
          i_term <= I_MIN[ITERM_W-1:0];
        else
          i_term <= q_signed[ITERM_W-1:0];
      end
      default: ;
    endcase
    if (out_load) m_tdata <= {{(OUT_DATA_W-$bits(result_t)){1'b0}}, result};
  end

endmodule

/* rtl/core/quadrature_speed_pi_controller.sv */
// quadrature_speed_pi_controller: top level; configuration registers and
// the front end, tick queue and PI back end. Depends on qspc_pkg.
//
// Takes one input word per clock while s_tready is high. A pin sample
// (tuser = 0) updates the quadrature position and fault count in the
// cycle it is accepted and gives no result. A control tick (tuser = 1)
// snapshots speed, error, position and fault count in the front end and
// enters a QUEUE_DEPTH deep queue; s_tready drops only while that queue
// is full. The back end takes one tick at a time: integrator clamp, the
// P and I multiplies, a divide of the I product by 1000 as a shift and a
// reciprocal multiply, and the duty clamp. It takes no new tick until the
// result is loaded into the output register, which waits while a held
// result is stalled. The result sits in the output register while the
// back end starts on the next tick.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the
// next clock edge; an index of 3 is ignored.
module quadrature_speed_pi_controller #(
  parameter int QUEUE_DEPTH = qspc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // pin_a [0], pin_b [1], setpoint [17:2], zero pad [23:18]
  input  logic [qspc_pkg::IN_DATA_W-1:0]      s_tdata,
  // opcode: 0 pin sample, 1 control tick
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // duty [7:0], speed_error [39:8], p_term [71:40], i_term [98:72],
  // position [130:99], speed [162:131], fault_count [178:163], zero pad
  output logic [qspc_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                                cfg_we,
  input  logic [qspc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qspc_pkg::CFG_W-1:0]          cfg_data
);
  import qspc_pkg::*;

  cfg_t      cfg;
  logic      full;
  logic      empty;
  logic      push;
  logic      pop;
  tick_rec_t push_rec;
  tick_rec_t pop_rec;

  // register file; reset values match the controller defaults
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp               <= KP_W'(1);
      cfg.ki_times_period  <= KI_W'(240);
      cfg.integrator_limit <= LIMIT_W'(900);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KP:    cfg.kp               <= cfg_data[KP_W-1:0];
        REG_KI:    cfg.ki_times_period  <= cfg_data[KI_W-1:0];
        REG_LIMIT: cfg.integrator_limit <= cfg_data[LIMIT_W-1:0];
        default:   ;
      endcase
    end
  end

  qspc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .full     (full),
    .push     (push),
    .push_rec (push_rec)
  );

  qspc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_rec),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_rec),
    .empty     (empty)
  );

  qspc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .empty    (empty),
    .pop_data (pop_rec),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

/* rtl/core/qspc_checker.sv */
// qspc_checker: port-level assertions for the quadrature speed PI controller,
// bound to the top level. Depends on qspc_pkg.
module qspc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [qspc_pkg::OUT_DATA_W-1:0] m_tdata
);
  import qspc_pkg::*;

  logic        [DUTY_W-1:0]  duty;
  logic signed [WORD_W-1:0]  p_term;
  logic signed [ITERM_W-1:0] i_term;

  assign duty   = m_tdata[7:0];
  assign p_term = m_tdata[71:40];
  assign i_term = m_tdata[98:72];

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_rst_rdy: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  a_duty_low: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && p_term[WORD_W-1] && i_term[ITERM_W-1] |-> duty == '0)
    else $error("duty not zero for negative P and I");

  a_duty_high: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (p_term > 32'sd254) && !i_term[ITERM_W-1] |-> duty == '1)
    else $error("duty not full scale for large P and positive I");

endmodule

bind quadrature_speed_pi_controller qspc_checker u_qspc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* verif/tb_top.sv */
// tb_top: self-checking testbench for quadrature_speed_pi_controller.
// Streams pin-sample and tick words, predicts each result word and checks
// it field by field. Depends on qspc_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_top;
  import qspc_pkg::*;

  localparam int     CLK_HALF     = 5;
  localparam int     RESET_CYCLES = 5;
  localparam int     DRAIN_CYCLES = 60;
  localparam int     LIMIT_CYCLES = 400000;
  localparam int     NUM_SETTINGS = 6;
  localparam int     RANDOM_WORDS = 235;     // per setting
  localparam int     RES_W        = $bits(result_t);
  localparam longint I_SCALE      = 1000;
  localparam longint P_MAX        = 64'sd2147483647;
  localparam longint P_MIN        = -64'sd2147483648;
  localparam longint ITERM_MAX    = 64'sd67108863;
  localparam longint ITERM_MIN    = -64'sd67108864;
  localparam longint DUTY_MAX     = 64'sd255;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Forward quadrature sequence, pins {B,A}: 0 -> 2 -> 3 -> 1, two bits per phase
  localparam logic [7:0] GRAY_SEQ = {2'd1, 2'd3, 2'd2, 2'd0};

  // Step per transition, index {last B, last A, cur B, cur A}, entry 0 lowest
  localparam logic [31:0] STEP_TABLE = {
    STEP_HOLD, STEP_DOWN, STEP_UP,   STEP_BAD,
    STEP_UP,   STEP_HOLD, STEP_BAD,  STEP_DOWN,
    STEP_DOWN, STEP_BAD,  STEP_HOLD, STEP_UP,
    STEP_BAD,  STEP_UP,   STEP_DOWN, STEP_HOLD
  };

  // Pin walk from reset that takes all sixteen transitions once, first lowest
  localparam logic [31:0] ALL_TRANSITIONS = {
    2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd3, 2'd0, 2'd2,
    2'd0, 2'd3, 2'd3, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0
  };

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;   // pin_a [0], pin_b [1], setpoint [17:2], pad
  logic                  s_tuser   = 1'b0; // opcode
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;          // duty, speed_error, p_term, i_term,
                                           // position, speed, fault_count, pad
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data  = '0;

  quadrature_speed_pi_controller dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // One input word waiting for the driver. wait_drained holds the word back
  // until every result already owed has come out.
  typedef struct {
    logic        tick;
    logic [1:0]  pins;       // bit0 A, bit1 B
    logic [15:0] setpoint;
    bit          wait_drained;
  } in_word_t;

  in_word_t pending_words[$];
  result_t  expected_results[$];

  int         mismatches     = 0;
  int         cycle_count    = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  bit         in_fire        = 1'b0;  // word taken at the last rising edge
  logic [1:0] gen_phase      = 2'd0;  // stimulus-side encoder phase

  // Predicted block state and registers
  logic [1:0]         pred_pins;
  logic [WORD_W-1:0]  pred_position;
  logic [WORD_W-1:0]  pred_tick_position;
  logic [FAULT_W-1:0] pred_faults;
  longint             pred_integ;
  logic [KP_W-1:0]    pred_kp;
  logic [KI_W-1:0]    pred_ki;
  logic [LIMIT_W-1:0] pred_limit;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Pin samples move the position or count a double transition; a tick
  // runs one PI step and owes one result word.
  task automatic update_encoder_and_pi(input logic tick, input logic [IN_DATA_W-1:0] data);
    int                idx;
    step_t             st;
    logic [WORD_W-1:0] spd;
    logic [WORD_W-1:0] err_w;
    longint            err;
    longint            p;
    longint            i;
    longint            d;
    result_t           r;
    if (tick == OP_PIN) begin
      idx = int'({pred_pins, data[1:0]});
      st  = step_t'(STEP_TABLE[idx*2 +: 2]);
      case (st)
        STEP_UP:   pred_position = pred_position + 32'd1;
        STEP_DOWN: pred_position = pred_position - 32'd1;
        STEP_BAD:  pred_faults   = pred_faults + 16'd1;
        default: ;
      endcase
      pred_pins = data[1:0];
    end else begin
      spd   = pred_position - pred_tick_position;
      err_w = {16'd0, data[17:2]} - spd;
      err   = longint'($signed(err_w));
      pred_tick_position = pred_position;
      // integrator clamps first; the I term sees the clamped sum
      pred_integ = clamp(pred_integ + err, -longint'(pred_limit), longint'(pred_limit));
      p = clamp(err * longint'(pred_kp), P_MIN, P_MAX);
      i = clamp((pred_integ * longint'(pred_ki)) / I_SCALE, ITERM_MIN, ITERM_MAX);
      d = clamp(p + i, 0, DUTY_MAX);
      r.duty        = d[DUTY_W-1:0];
      r.speed_error = err_w;
      r.p_term      = p[WORD_W-1:0];
      r.i_term      = i[ITERM_W-1:0];
      r.position    = pred_position;
      r.speed       = spd;
      r.fault_count = pred_faults;
      expected_results.push_back(r);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Monitor: config writes, accepted input words and result words, all at
  // the rising edge.
  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    in_fire = 1'b0;
    if (rst) begin
      pred_pins          = 2'd0;
      pred_position      = '0;
      pred_tick_position = '0;
      pred_faults        = '0;
      pred_integ         = 0;
      pred_kp            = 8'd1;
      pred_ki            = 16'd240;
      pred_limit         = 20'd900;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KP:    pred_kp    = cfg_data[KP_W-1:0];
          REG_KI:    pred_ki    = cfg_data[KI_W-1:0];
          REG_LIMIT: pred_limit = cfg_data[LIMIT_W-1:0];
          default: ;  // unused index, no register behind it
        endcase
      end
      if (s_tvalid && s_tready) begin
        in_fire = 1'b1;
        update_encoder_and_pi(s_tuser, s_tdata);
      end
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[RES_W-1:0]);
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result word with no expectation, actual %h", $time, m_tdata);
        end else begin
          want = expected_results.pop_front();
          compare_field("duty",        32'(want.duty),        32'(got.duty));
          compare_field("speed_error", want.speed_error,      got.speed_error);
          compare_field("p_term",      want.p_term,           got.p_term);
          compare_field("i_term",      32'(want.i_term),      32'(got.i_term));
          compare_field("position",    want.position,         got.position);
          compare_field("speed",       want.speed,            got.speed);
          compare_field("fault_count", 32'(want.fault_count), 32'(got.fault_count));
          compare_field("pad",         '0,                    32'(m_tdata[OUT_DATA_W-1:RES_W]));
        end
      end
    end
  end

  // Driver: everything changes on the falling edge.
  always @(negedge clk) begin : driver
    bit                   go;
    in_word_t             w;
    logic [IN_DATA_W-1:0] d;
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (!rst && (!s_tvalid || in_fire)) begin
      go = (pending_words.size() > 0) && ($urandom_range(0, 99) >= send_idle_pct);
      if (go && pending_words[0].wait_drained && expected_results.size() > 0) go = 1'b0;
      if (go) begin
        w       = pending_words.pop_front();
        d       = '0;
        d[1:0]  = w.pins;
        d[17:2] = w.setpoint;
        s_tvalid <= 1'b1;
        s_tuser  <= w.tick;
        s_tdata  <= d;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic queue_word(input logic tick, input logic [1:0] pins,
                            input logic [15:0] setpoint, input bit hold);
    in_word_t w;
    w.tick         = tick;
    w.pins         = pins;
    w.setpoint     = setpoint;
    w.wait_drained = hold;
    pending_words.push_back(w);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  // Idle means no word queued or on the bus, no result owed, and the
  // back end given time to finish.
  task automatic wait_drained();
    while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly clean encoder walks closed by a tick, plus tick bursts at the
  // setpoint extremes to drive the integrator into its clamps, pin noise
  // with double transitions, and lone ticks at any setpoint.
  task automatic queue_random_words(input int count);
    int n;
    int sel;
    int len;
    int r;
    bit dir;
    logic [15:0] sp;
    n = 0;
    while (n < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 65) begin
        len = $urandom_range(1, 30);
        dir = 1'($urandom_range(0, 1));
        for (int k = 0; k < len; k++) begin
          r = $urandom_range(0, 19);
          if (r == 1) gen_phase = gen_phase + 2'd2;      // both pins flip
          else if (r != 0) gen_phase = gen_phase + (dir ? 2'd1 : 2'd3);
          queue_word(OP_PIN, GRAY_SEQ[gen_phase*2 +: 2], 16'($urandom_range(0, 65535)),
                     1'b0);
        end
        sp = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                         : 16'($urandom_range(0, 40));
        queue_word(OP_TICK, 2'($urandom_range(0, 3)), sp, 1'b0);
        n += len + 1;
      end else if (sel < 72) begin
        len = $urandom_range(1, 20);
        sp  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        for (int k = 0; k < len; k++)
          queue_word(OP_TICK, 2'($urandom_range(0, 3)), sp, 1'b0);
        n += len;
      end else if (sel < 87) begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          gen_phase = 2'($urandom_range(0, 3));
          queue_word(OP_PIN, GRAY_SEQ[gen_phase*2 +: 2], 16'($urandom_range(0, 65535)),
                     1'b0);
        end
        n += len;
      end else begin
        queue_word(OP_TICK, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                   $urandom_range(0, 7) == 0);
        n += 1;
      end
    end
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, reset registers, no idling: every pin transition with
    // garbage setpoints, then ticks at the setpoint extremes with garbage
    // pins; the repeated full-scale ticks hit the integrator clamp.
    for (int k = 0; k < 16; k++)
      queue_word(OP_PIN, ALL_TRANSITIONS[k*2 +: 2],
                 (k % 2 == 0) ? 16'hFFFF : 16'($urandom_range(0, 65535)), 1'b0);
    queue_word(OP_TICK, 2'd3, 16'h0000, 1'b0);
    queue_word(OP_TICK, 2'd0, 16'hFFFF, 1'b0);
    queue_word(OP_TICK, 2'd1, 16'hFFFF, 1'b1);   // sender holds until drained
    queue_word(OP_TICK, 2'd2, 16'hFFFF, 1'b0);
    queue_word(OP_TICK, 2'd3, 16'h0000, 1'b0);

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      wait_drained();
      case (s)
        0: begin  // all maxima, I term saturates
          write_reg(REG_KP,    CFG_W'(255));
          write_reg(REG_KI,    CFG_W'(16'hFFFF));
          write_reg(REG_LIMIT, CFG_W'(20'hFFFFF));
        end
        1: begin  // all zero
          write_reg(REG_KP,    '0);
          write_reg(REG_KI,    '0);
          write_reg(REG_LIMIT, '0);
        end
        2: begin  // unused index must not touch anything
          write_reg(REG_KP,     CFG_W'(4));
          write_reg(REG_KI,     CFG_W'(500));
          write_reg(REG_LIMIT,  CFG_W'(1000000));
          write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 20'hFFFFF)));
        end
        3: begin
          write_reg(REG_KP,    CFG_W'($urandom_range(0, 255)));
          write_reg(REG_KI,    CFG_W'($urandom_range(0, 65535)));
          write_reg(REG_LIMIT, CFG_W'($urandom_range(0, 20'hFFFFF)));
        end
        4: begin  // back to reset values
          write_reg(REG_KP,    CFG_W'(1));
          write_reg(REG_KI,    CFG_W'(240));
          write_reg(REG_LIMIT, CFG_W'(900));
        end
        default: begin
          write_reg(REG_KP,    CFG_W'(20));
          write_reg(REG_KI,    CFG_W'(1000));
          write_reg(REG_LIMIT, CFG_W'(5000));
        end
      endcase
      @(negedge clk);
      cfg_we <= 1'b0;

      // idle modes: none, sender, receiver, both
      case ((s + 1) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      queue_random_words(RANDOM_WORDS);
    end

    wait_drained();
    if (expected_results.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
    end
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/qspc_pkg.sv
rtl/core/qspc_front.sv
rtl/core/qspc_fifo.sv
rtl/core/qspc_back.sv
rtl/core/quadrature_speed_pi_controller.sv
rtl/core/qspc_checker.sv
verif/tb_top.sv
